>>> rtl/core/bbcs_pkg.sv
// shared types, base codes and error table functions for the bisulfite sampler
package bbcs_pkg;

  // 4-bit nucleotide codes
  localparam logic [3:0] BASE_A = 4'd1;
  localparam logic [3:0] BASE_C = 4'd2;
  localparam logic [3:0] BASE_G = 4'd4;
  localparam logic [3:0] BASE_T = 4'd8;

  // weight lane order: A, C, T, G
  localparam logic [1:0] IDX_A = 2'd0;
  localparam logic [1:0] IDX_C = 2'd1;
  localparam logic [1:0] IDX_T = 2'd2;
  localparam logic [1:0] IDX_G = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LAMBDA = 2'd0;
  localparam logic [1:0] REG_TAU    = 2'd1;
  localparam logic [1:0] REG_METH   = 2'd2;

  localparam int unsigned Q16_W   = 17;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam int unsigned RND_W   = 24;
  localparam int unsigned ROM_W   = 33;

  localparam longint unsigned DEC_SCALE = 64'd1000000000000000000;
  localparam longint unsigned TEN_POW [10] = '{
    64'd1000000000000000000, 64'd794328234724281502, 64'd630957344480193249,
    64'd501187233627272285,  64'd398107170553497250, 64'd316227766016837933,
    64'd251188643150958011,  64'd199526231496887960, 64'd158489319246111349,
    64'd125892541179416721
  };

  // sideband that travels with each request through the pipeline
  typedef struct packed {
    logic [3:0]       code;
    logic [3:0]       nt;
    logic             rev;
    logic             unsup;
    logic             last;
    logic [RND_W-1:0] rnd;
  } bbcs_side_t;

  function automatic logic [3:0] comp_base(input logic [3:0] b);
    logic [3:0] r;
    case (b)
      BASE_A:  r = BASE_T;
      BASE_C:  r = BASE_G;
      BASE_G:  r = BASE_C;
      BASE_T:  r = BASE_A;
      default: r = b;
    endcase
    return r;
  endfunction

  // 10^(-q/10) in Q1.pbits, rounded half up, saturated to one
  function automatic logic [ROM_W-1:0] err_of(input int unsigned q, input int unsigned pbits);
    longint unsigned v;
    longint unsigned quo;
    longint unsigned rem;
    int unsigned     k;
    int              i;
    v = TEN_POW[q % 10];
    k = q / 10;
    for (i = 0; i < 26; i++) begin
      if (k > 0 && v > 0) begin
        v = v / 10;
        k = k - 1;
      end
    end
    quo = v / DEC_SCALE;
    rem = v % DEC_SCALE;
    for (i = 0; i < ROM_W; i++) begin
      if (i < pbits + 1) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= DEC_SCALE) begin
          rem = rem - DEC_SCALE;
          quo = quo | 64'd1;
        end
      end
    end
    quo = (quo + 64'd1) >> 1;
    if (quo > (64'd1 << pbits)) begin
      quo = 64'd1 << pbits;
    end
    return quo[ROM_W-1:0];
  endfunction

  // (e + 1) / 3 of the same entry
  function automatic logic [ROM_W-1:0] err3_of(input int unsigned q, input int unsigned pbits);
    longint unsigned e;
    e = 64'(err_of(q, pbits));
    e = (e + 64'd1) / 3;
    return e[ROM_W-1:0];
  endfunction

endpackage

>>> rtl/core/bbcs_pick.sv
// weight totals, random scaling and cumulative pick with the output register
module bbcs_pick import bbcs_pkg::*; #(
  parameter int unsigned PROB_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [PROB_BITS+1:0] w_a_i,
  input  logic [PROB_BITS+1:0] w_c_i,
  input  logic [PROB_BITS+1:0] w_t_i,
  input  logic [PROB_BITS+1:0] w_g_i,
  input  bbcs_side_t       side_i,
  output logic             adv_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_base[3:0], base_changed, unsupported_code
  output logic             m_axis_tlast
);

  localparam int unsigned TW = PROB_BITS + 4;
  localparam int unsigned MW = TW + RND_W;

  logic adv;

  // stage 8: pairwise sums
  logic            v8_q;
  bbcs_side_t      side8_q;
  logic [TW-1:0]   a8_q, t8_q, ac8_q, tg8_q;
  // stage 9: prefix and total
  logic            v9_q;
  bbcs_side_t      side9_q;
  logic [TW-1:0]   a9_q, ac9_q, act9_q, tot9_q;
  // stage 10: scaled random
  logic            v10_q;
  bbcs_side_t      side10_q;
  logic [TW-1:0]   a10_q, ac10_q, act10_q, tot10_q, thr10_q;
  logic [MW-1:0]   prod10;
  // output register
  logic            out_vld_q;
  logic [3:0]      base_q;
  logic            chg_q, uns_q, last_q;
  logic [3:0]      pick, base_d;
  logic            chg_d;

  assign adv   = !out_vld_q || m_axis_tready;
  assign adv_o = adv;

  assign prod10 = MW'(side9_q.rnd) * MW'(tot9_q);

  always_comb begin
    if (thr10_q < a10_q) begin
      pick = BASE_A;
    end else if (thr10_q < ac10_q) begin
      pick = BASE_C;
    end else if (thr10_q < act10_q) begin
      pick = BASE_T;
    end else begin
      pick = BASE_G;
    end
    if (side10_q.unsup) begin
      base_d = side10_q.code;
      chg_d  = 1'b0;
    end else begin
      base_d = side10_q.rev ? comp_base(pick) : pick;
      chg_d  = (pick != side10_q.nt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v8_q      <= in_valid_i;
      v9_q      <= v8_q;
      v10_q     <= v9_q;
      out_vld_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side8_q  <= side_i;
      a8_q     <= TW'(w_a_i);
      t8_q     <= TW'(w_t_i);
      ac8_q    <= TW'(w_a_i) + TW'(w_c_i);
      tg8_q    <= TW'(w_t_i) + TW'(w_g_i);

      side9_q  <= side8_q;
      a9_q     <= a8_q;
      ac9_q    <= ac8_q;
      act9_q   <= ac8_q + t8_q;
      tot9_q   <= ac8_q + tg8_q;

      side10_q <= side9_q;
      a10_q    <= a9_q;
      ac10_q   <= ac9_q;
      act10_q  <= act9_q;
      tot10_q  <= tot9_q;
      thr10_q  <= prod10[MW-1:RND_W];

      base_q   <= base_d;
      chg_q    <= chg_d;
      uns_q    <= side10_q.unsup;
      last_q   <= side10_q.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, uns_q, chg_q, base_q};
  assign m_axis_tlast  = last_q;

  a_thr_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v10_q && !side10_q.unsup && (tot10_q != '0) |-> thr10_q < tot10_q)
    else $error("scaled random not below weight total");

  a_prefix_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v9_q |-> (a9_q <= ac9_q) && (ac9_q <= act9_q) && (act9_q <= tot9_q))
    else $error("cumulative weights out of order");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v9_q && adv |=> v10_q)
    else $error("request lost between scale and pick stages");

endmodule

>>> rtl/core/bisulfite_base_conversion_sampler.sv
// top level: error lookup, bisulfite posterior weights and base draw, one base per clock
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid / tready            tdata: base_code[3:0] quality[11:4]
//                                           reverse_strand[12] meth_override_valid[13]
//                                           meth_override[30:14] random_value[54:31]
//                                           tlast: last_in_read
// m_axis    out  tvalid / tready            tdata: out_base[3:0] base_changed[4]
//                                           unsupported_code[5]; tlast: last_out
// cfg       in   cfg_we_i (no wait)         cfg_idx_i selects lambda, tau, methylation
//
// one request per clock sustained unless the output register is full and not taken
// eleven register stages: rom/decode, methylation split products, conversion products,
// conversion sums, weight sums, error-mix products, final weights, pairwise sums,
// totals, random scaling, pick/output register
// all stages advance together; the whole pipe freezes only when the output register
// is full and not taken, so s_axis_tready is low exactly then
// reset clears all valid bits and loads lambda = 1.0, tau = 0, methylation = 0
module bisulfite_base_conversion_sampler import bbcs_pkg::*; #(
  parameter int unsigned PROB_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // base_code, quality, reverse_strand,
                                      // meth_override_valid, meth_override, random_value
  input  logic        s_axis_tlast,   // last_in_read
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_base, base_changed, unsupported_code
  output logic        m_axis_tlast,   // last_out
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  localparam int unsigned PW  = PROB_BITS + 1;   // probability incl. 1.0
  localparam int unsigned PW2 = 2 * PROB_BITS + 2;
  localparam int unsigned SW  = PROB_BITS + 3;   // sums of up to four weights
  localparam int unsigned WW  = PROB_BITS + 2;   // final weights
  localparam logic [PW-1:0] ONE  = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF = ONE >> 1;

  // rounded product of two probabilities, both at most one
  function automatic logic [PW-1:0] mulp(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW2-1:0] pr;
    pr = PW2'(a) * PW2'(b) + PW2'(HALF);
    return pr[2*PROB_BITS:PROB_BITS];
  endfunction

  // saturate a grown sum to one
  function automatic logic [PW-1:0] satp(input logic [SW-1:0] x);
    return (x > SW'(ONE)) ? ONE : x[PW-1:0];
  endfunction

  // Q1.16 register value to Q1.PROB_BITS, saturated
  function automatic logic [PW-1:0] q16p(input logic [Q16_W-1:0] x);
    logic [Q16_W-1:0] s;
    s = (x > Q16_ONE) ? Q16_ONE : x;
    return PW'(s) << (PROB_BITS - 16);
  endfunction

  // configuration registers
  logic [Q16_W-1:0] lam_q, tau_q, meth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q  <= Q16_ONE;
      tau_q  <= '0;
      meth_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LAMBDA: lam_q  <= cfg_wdata_i;
        REG_TAU:    tau_q  <= cfg_wdata_i;
        REG_METH:   meth_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  logic [PW-1:0] lam_p, tau_p;
  assign lam_p = q16p(lam_q);
  assign tau_p = q16p(tau_q);

  // error tables, fixed at elaboration
  logic [PW-1:0] err_rom  [256];
  logic [PW-1:0] err3_rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign err_rom[g]  = PW'(err_of(g, PROB_BITS));
    assign err3_rom[g] = PW'(err3_of(g, PROB_BITS));
  end

  // input unpacking
  logic [3:0]       in_code;
  logic [7:0]       in_qual;
  logic             in_rev, in_ovr;
  logic [Q16_W-1:0] in_movr;
  logic [RND_W-1:0] in_rnd;

  assign in_code = s_axis_tdata[3:0];
  assign in_qual = s_axis_tdata[11:4];
  assign in_rev  = s_axis_tdata[12];
  assign in_ovr  = s_axis_tdata[13];
  assign in_movr = s_axis_tdata[30:14];
  assign in_rnd  = s_axis_tdata[54:31];

  logic adv;
  assign s_axis_tready = adv;

  // stage 1: strand fold, lane decode, error lookup, prior weights
  logic [3:0]    nt;
  logic          unsup;
  logic [1:0]    obs;
  logic [PW-1:0] e_d, e3_d, ce_d;
  bbcs_side_t    side_d;

  always_comb begin
    nt    = in_rev ? comp_base(in_code) : in_code;
    unsup = 1'b0;
    case (nt)
      BASE_A:  obs = IDX_A;
      BASE_C:  obs = IDX_C;
      BASE_T:  obs = IDX_T;
      BASE_G:  obs = IDX_G;
      default: begin
        obs   = IDX_A;
        unsup = 1'b1;
      end
    endcase
    e_d  = err_rom[in_qual];
    e3_d = err3_rom[in_qual];
    ce_d = ONE - e_d;
    side_d = '{code: in_code, nt: nt, rev: in_rev, unsup: unsup,
               last: s_axis_tlast, rnd: in_rnd};
  end

  logic          v1_q;
  bbcs_side_t    side1_q;
  logic [PW-1:0] e1_q, e3_1_q, ce1_q, m1_q;
  logic [PW-1:0] w2_q [4];

  // stage 2: methylated / unmethylated split of the C weight
  logic          v2_q;
  bbcs_side_t    side2_q;
  logic [PW-1:0] e3_2_q, ce2_q, a2_q, t2_q, g2_q, cm3_q, c3_q;

  // stage 3: conversion products
  logic          v3_q;
  bbcs_side_t    side3_q;
  logic [PW-1:0] e3_3_q, ce3_q, a3_q, t3_q, g3_q;
  logic [PW-1:0] pcm_keep_q, pc_keep_q, pcm_conv_q, pc_conv_q;

  // stage 4: converted C and T weights
  logic          v4_q;
  bbcs_side_t    side4_q;
  logic [PW-1:0] e3_4_q, ce4_q;
  logic [PW-1:0] w4_q [4];

  // stage 5: weight sum and the "other three" sums
  logic          v5_q;
  bbcs_side_t    side5_q;
  logic [PW-1:0] e3_5_q, ce5_q;
  logic [PW-1:0] x5_q [4];
  logic [PW-1:0] oth5_q [4];
  logic [SW-1:0] sum4;

  // stage 6: error-mix products
  logic          v6_q;
  bbcs_side_t    side6_q;
  logic [PW-1:0] pk6_q [4];
  logic [PW-1:0] po6_q [4];

  // stage 7: final weights
  logic          v7_q;
  bbcs_side_t    side7_q;
  logic [WW-1:0] w5_q [4];

  assign sum4 = SW'(w4_q[IDX_A]) + SW'(w4_q[IDX_C]) + SW'(w4_q[IDX_T]) + SW'(w4_q[IDX_G]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      side1_q <= side_d;
      e1_q    <= e_d;
      e3_1_q  <= e3_d;
      ce1_q   <= ce_d;
      m1_q    <= q16p(in_ovr ? in_movr : meth_q);
      for (int i = 0; i < 4; i++) begin
        w2_q[i] <= (obs == 2'(i)) ? ce_d : e3_d;
      end

      // stage 2
      side2_q <= side1_q;
      e3_2_q  <= e3_1_q;
      ce2_q   <= ce1_q;
      a2_q    <= w2_q[IDX_A];
      t2_q    <= w2_q[IDX_T];
      g2_q    <= w2_q[IDX_G];
      cm3_q   <= mulp(m1_q, w2_q[IDX_C]);
      c3_q    <= mulp(ONE - m1_q, w2_q[IDX_C]);

      // stage 3
      side3_q    <= side2_q;
      e3_3_q     <= e3_2_q;
      ce3_q      <= ce2_q;
      a3_q       <= a2_q;
      t3_q       <= t2_q;
      g3_q       <= g2_q;
      pcm_keep_q <= mulp(ONE - tau_p, cm3_q);
      pc_keep_q  <= mulp(ONE - lam_p, c3_q);
      pcm_conv_q <= mulp(tau_p, cm3_q);
      pc_conv_q  <= mulp(lam_p, c3_q);

      // stage 4
      side4_q      <= side3_q;
      e3_4_q       <= e3_3_q;
      ce4_q        <= ce3_q;
      w4_q[IDX_A]  <= a3_q;
      w4_q[IDX_C]  <= satp(SW'(pcm_keep_q) + SW'(pc_keep_q));
      w4_q[IDX_T]  <= satp(SW'(pcm_conv_q) + SW'(pc_conv_q) + SW'(t3_q));
      w4_q[IDX_G]  <= g3_q;

      // stage 5
      side5_q <= side4_q;
      e3_5_q  <= e3_4_q;
      ce5_q   <= ce4_q;
      for (int i = 0; i < 4; i++) begin
        x5_q[i]   <= w4_q[i];
        oth5_q[i] <= satp(sum4 - SW'(w4_q[i]));
      end

      // stage 6
      side6_q <= side5_q;
      for (int i = 0; i < 4; i++) begin
        pk6_q[i] <= mulp(ce5_q, x5_q[i]);
        po6_q[i] <= mulp(e3_5_q, oth5_q[i]);
      end

      // stage 7
      side7_q <= side6_q;
      for (int i = 0; i < 4; i++) begin
        w5_q[i] <= WW'(pk6_q[i]) + WW'(po6_q[i]);
      end
    end
  end

  // totals, random scaling, pick and output register
  bbcs_pick #(
    .PROB_BITS (PROB_BITS)
  ) u_pick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v7_q),
    .w_a_i         (w5_q[IDX_A]),
    .w_c_i         (w5_q[IDX_C]),
    .w_t_i         (w5_q[IDX_T]),
    .w_g_i         (w5_q[IDX_G]),
    .side_i        (side7_q),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_err3_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ((SW'(e3_1_q) * 3) <= (SW'(e1_q) + 1)) &&
             ((SW'(e1_q) + 1) < (SW'(e3_1_q) * 3 + 3)))
    else $error("error third table inconsistent with error table");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted request missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v7_q) && $stable(v1_q))
    else $error("pipeline moved during stall");

  a_split_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !side2_q.unsup |-> (SW'(cm3_q) + SW'(c3_q)) <= (SW'(ONE) + 1))
    else $error("methylation split exceeds one");

endmodule
